[hdl/rtwhe_pkg.sv]
package rtwhe_pkg;

  // Smallest capture that can carry a radiotap header
  localparam int MIN_CAPTURE_HEADER = 8;

  // 802.11 MAC header bytes needed after the radiotap header
  localparam int MAC_HDR_BYTES = 24;

  // Byte offsets inside the MAC header
  localparam int FC_LO_OFS   = 0;
  localparam int FC_HI_OFS   = 1;
  localparam int ADDR1_OFS   = 4;
  localparam int ADDR2_OFS   = 10;
  localparam int ADDR3_OFS   = 16;
  localparam int ADDR3_END   = 22;

  // Radiotap length sits at frame bytes 2 (low) and 3 (high)
  localparam int RT_LEN_LO_POS = 2;
  localparam int RT_LEN_HI_POS = 3;
  localparam int PREFIX_BYTES  = 4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Known subtype bits, one 16-bit row per frame type
  localparam logic [3:0][15:0] KIND_TABLE = '{16'h0003, 16'hDF11, 16'hFFFC, 16'h7F7F};

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rtwhe_in_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  frame_type;
    logic [3:0]  frame_subtype;
    logic        known_kind;
    logic [47:0] dest_address;
    logic [47:0] source_address;
    logic [47:0] bss_address;
    logic [15:0] frame_length;
    logic [7:0]  channel_number;
  } rtwhe_out_t;

endpackage

[hdl/radiotap_wifi_header_extractor.sv]
// Radiotap / 802.11 header extractor. Takes captured frame bytes, one word
// per byte, with last_byte marking the end of a frame. The little-endian
// radiotap length at bytes 2-3 locates the MAC header; frame control and
// addresses 1..3 are captured from it. Exactly one result word leaves per
// frame, via the input register, then the result register. Throughput is
// one byte per cycle; the input side only stalls when a last byte is held
// while the result register is still full and not being taken. Status is
// "too short" for captures below MIN_CAPTURE_HEADER bytes or below radiotap
// length + 24; then type, subtype, known flag and addresses read zero.
// frame_length saturates at 65535; later bytes are neither counted nor
// captured. The channel register is written through the cfg port (always
// ready) while no frame is open: a user rule the block does not enforce.
module radiotap_wifi_header_extractor
  import rtwhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rtwhe_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rtwhe_out_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // Input register
  logic       in_vld_r;
  rtwhe_in_t  in_r;

  // Frame state
  logic [15:0]     cnt_r,   cnt_upd,   cnt_nxt;
  logic [15:0]     hdr_r,   hdr_upd,   hdr_nxt;
  logic [15:0]     cw_r,    cw_upd,    cw_nxt;
  logic [47:0]     a1_r,    a1_upd,    a1_nxt;
  logic [47:0]     a2_r,    a2_upd,    a2_nxt;
  logic [47:0]     a3_r,    a3_upd,    a3_nxt;
  logic [3:0][7:0] pre_r,   pre_upd,   pre_nxt;
  logic [15:0]     off;

  // Result register and config
  logic       out_valid_r, out_valid_nxt;
  rtwhe_out_t out_r, out_nxt;
  logic [7:0] chan_r;

  logic adv;       // stage 2 consumes its byte this cycle
  logic fire;      // a last byte is consumed: load a result
  logic bad;
  logic [16:0] need;
  logic [7:0]  fc_lo, fc_hi;
  logic [15:0] fc;

  assign adv      = !in_r.last_byte || !out_valid_r || out_ready;
  assign in_ready = !in_vld_r || adv;
  assign fire     = in_vld_r && in_r.last_byte && adv;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Per-byte state update
  always_comb begin
    cnt_upd = cnt_r;
    hdr_upd = hdr_r;
    cw_upd  = cw_r;
    a1_upd  = a1_r;
    a2_upd  = a2_r;
    a3_upd  = a3_r;
    pre_upd = pre_r;
    off     = cnt_r - hdr_r;
    if (in_vld_r && adv && cnt_r != COUNT_MAX) begin
      if (cnt_r < 16'(PREFIX_BYTES)) begin
        pre_upd[cnt_r[1:0]] = in_r.data_byte;
      end
      if (cnt_r == 16'(RT_LEN_LO_POS)) begin
        hdr_upd[7:0] = in_r.data_byte;
      end else if (cnt_r == 16'(RT_LEN_HI_POS)) begin
        hdr_upd[15:8] = in_r.data_byte;
      end else if (cnt_r >= 16'(PREFIX_BYTES) && cnt_r >= hdr_r) begin
        if (off == 16'(FC_LO_OFS)) begin
          cw_upd[7:0] = in_r.data_byte;
        end else if (off == 16'(FC_HI_OFS)) begin
          cw_upd[15:8] = in_r.data_byte;
        end else if (off >= 16'(ADDR1_OFS) && off < 16'(ADDR2_OFS)) begin
          a1_upd = {a1_r[39:0], in_r.data_byte};
        end else if (off >= 16'(ADDR2_OFS) && off < 16'(ADDR3_OFS)) begin
          a2_upd = {a2_r[39:0], in_r.data_byte};
        end else if (off >= 16'(ADDR3_OFS) && off < 16'(ADDR3_END)) begin
          a3_upd = {a3_r[39:0], in_r.data_byte};
        end
      end
      cnt_upd = cnt_r + 16'd1;
    end

    // A finished frame leaves clean state behind
    cnt_nxt = fire ? '0 : cnt_upd;
    hdr_nxt = fire ? '0 : hdr_upd;
    cw_nxt  = fire ? '0 : cw_upd;
    a1_nxt  = fire ? '0 : a1_upd;
    a2_nxt  = fire ? '0 : a2_upd;
    a3_nxt  = fire ? '0 : a3_upd;
    pre_nxt = fire ? '0 : pre_upd;
  end

  // Result build from the updated frame state
  always_comb begin
    need = {1'b0, hdr_upd} + 17'(MAC_HDR_BYTES);
    bad  = (cnt_upd < 16'(MIN_CAPTURE_HEADER)) || ({1'b0, cnt_upd} < need);
    // Tiny radiotap lengths put frame control inside the first four bytes
    fc_lo = (hdr_upd < 16'(PREFIX_BYTES)) ? pre_upd[hdr_upd[1:0]] : cw_upd[7:0];
    fc_hi = (hdr_upd < 16'(PREFIX_BYTES - 1)) ? pre_upd[hdr_upd[1:0] + 2'd1]
                                              : cw_upd[15:8];
    fc = {fc_hi, fc_lo};

    out_nxt                = out_r;
    out_valid_nxt          = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = bad ? STATUS_SHORT : STATUS_OK;
      out_nxt.frame_length   = cnt_upd;
      out_nxt.channel_number = chan_r;
      if (bad) begin
        out_nxt.frame_type     = '0;
        out_nxt.frame_subtype  = '0;
        out_nxt.known_kind     = 1'b0;
        out_nxt.dest_address   = '0;
        out_nxt.source_address = '0;
        out_nxt.bss_address    = '0;
      end else begin
        out_nxt.frame_type     = fc[3:2];
        out_nxt.frame_subtype  = fc[7:4];
        out_nxt.known_kind     = KIND_TABLE[fc[3:2]][fc[7:4]];
        out_nxt.dest_address   = a1_upd;
        out_nxt.source_address = a2_upd;
        out_nxt.bss_address    = a3_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      chan_r      <= '0;
      cnt_r       <= '0;
      hdr_r       <= '0;
      cw_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      a3_r        <= '0;
      pre_r       <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        chan_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      cw_r        <= cw_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      a3_r        <= a3_nxt;
      pre_r       <= pre_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // A consumed last byte always lands a result and reopens the frame
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && cnt_r == 16'd0 && hdr_r == 16'd0))
    else $error("last byte did not produce a result or clear state");

  // A good frame holds at least a bare MAC header and the minimum capture
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_OK) |->
      (out_r.frame_length >= 16'(MAC_HDR_BYTES) &&
       out_r.frame_length >= 16'(MIN_CAPTURE_HEADER)))
    else $error("ok status on a frame below minimum length");

  // Short frames report no header fields
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_SHORT) |->
      (out_r.frame_type == 2'd0 && !out_r.known_kind && out_r.dest_address == 48'd0))
    else $error("short frame carries header fields");

  // A pending result is never overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !fire)
    else $error("result register overwritten while held");

endmodule

[tb/tb_radiotap_wifi_header_extractor.sv]
`timescale 1ns / 100ps

module tb_radiotap_wifi_header_extractor;
  import rtwhe_pkg::*;

  // Bytes of MAC header needed after the radiotap header: fc, dur, addr1..3, seq
  localparam int HDR_LEN = 24;
  // Frame bytes that are counted at all; later bytes only saturate the length
  localparam logic [15:0] LEN_SAT = 16'hFFFF;
  // Hard stop, far above the slowest passing run with its stalls
  localparam int RUN_LIMIT_NS = 3_000_000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONE} fill_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  rtwhe_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  rtwhe_out_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  radiotap_wifi_header_extractor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Header parser shadow: own copy of the per-frame capture state and of the
  // channel register. Advanced once per accepted byte word.
  // ---------------------------------------------------------------------------
  logic [15:0] pos_cnt;     // bytes seen in the open frame (saturating)
  logic [15:0] rt_len;      // radiotap length from bytes 2 (lo) and 3 (hi)
  logic [15:0] fc_word;     // frame control, when it sits past the prefix
  logic [47:0] addr1, addr2, addr3;
  logic [31:0] prefix;      // first four frame bytes, byte 0 in bits 7:0
  logic [7:0]  chan;

  rtwhe_out_t expected_hdrs[$];

  // Run bookkeeping
  int unsigned mismatch_cnt;
  int unsigned hdrs_checked;
  int unsigned short_checked;
  int unsigned known_checked;
  int unsigned bytes_sent;
  int unsigned chan_writes;

  // Sender burst shaping
  bit tx_gap_on;
  int burst_left;

  // Receiver stall control
  rx_mode_t rx_mode;
  int       rx_hold_req;
  int       rx_hold_cnt;
  int       rx_tick;

  task automatic clear_frame_state();
    pos_cnt = '0;
    rt_len  = '0;
    fc_word = '0;
    addr1   = '0;
    addr2   = '0;
    addr3   = '0;
    prefix  = '0;
  endtask

  // Advance the shadow by one byte; on the last byte queue the header result.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] p;
    logic [15:0] off;
    logic [7:0]  fc_lo, fc_hi;
    logic [15:0] kind_row;
    int          rt;
    bit          too_short;
    rtwhe_out_t  hdr;
    p = pos_cnt;
    if (p != LEN_SAT) begin
      if (p < 4) prefix[p*8 +: 8] = b;
      if (p == 2) begin
        rt_len[7:0] = b;
      end else if (p == 3) begin
        rt_len[15:8] = b;
      end else if (p >= 4 && p >= rt_len) begin
        off = p - rt_len;
        if (off == 0)                 fc_word[7:0]  = b;
        else if (off == 1)            fc_word[15:8] = b;
        else if (off >= 4 && off < 10)  addr1 = {addr1[39:0], b};
        else if (off >= 10 && off < 16) addr2 = {addr2[39:0], b};
        else if (off >= 16 && off < 22) addr3 = {addr3[39:0], b};
      end
      pos_cnt = p + 16'd1;
    end
    if (last) begin
      rt = int'(rt_len);
      too_short = (int'(pos_cnt) < MIN_CAPTURE_HEADER) || (int'(pos_cnt) < rt + HDR_LEN);
      hdr = '0;
      hdr.status         = too_short ? STATUS_SHORT : STATUS_OK;
      hdr.frame_length   = pos_cnt;
      hdr.channel_number = chan;
      if (!too_short) begin
        // radiotap length below 4: frame control overlaps the prefix bytes
        fc_lo = (rt < 4)     ? prefix[rt*8 +: 8]       : fc_word[7:0];
        fc_hi = (rt + 1 < 4) ? prefix[(rt + 1)*8 +: 8] : fc_word[15:8];
        hdr.frame_type    = fc_lo[3:2];
        hdr.frame_subtype = fc_lo[7:4];
        case (fc_lo[3:2])
          2'd0:    kind_row = 16'h7F7F;  // management
          2'd1:    kind_row = 16'hFFFC;  // control
          2'd2:    kind_row = 16'hDF11;  // data
          default: kind_row = 16'h0003;  // extension
        endcase
        hdr.known_kind     = kind_row[fc_lo[7:4]];
        hdr.dest_address   = addr1;
        hdr.source_address = addr2;
        hdr.bss_address    = addr3;
      end
      expected_hdrs.push_back(hdr);
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one byte word per call, bursts of random length with random gaps.
  // Valid stays high across back-to-back words inside a burst.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk);
    if (tx_gap_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  // One captured frame: radiotap length at bytes 2-3, frame control at
  // offset rt (when past the prefix), everything else from the fill pattern.
  task automatic send_frame(input int rt, input int len, input logic [15:0] fc,
                            input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONE:  b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      if (i == 2)                   b = rt[7:0];
      else if (i == 3)              b = rt[15:8];
      else if (i >= 4 && i == rt)     b = fc[7:0];
      else if (i >= 4 && i == rt + 1) b = fc[15:8];
      send_byte(b, i == len - 1);
    end
  endtask

  // Sender pauses until every queued header has come back, then lets the
  // two-stage pipe settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_hdrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Channel register write, only with the block idle.
  task automatic set_channel(input logic [7:0] ch);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ch;
    do @(posedge clk); while (!cfg_ready);
    chan = ch;
    chan_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off counted here on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_tick++;
    if (rx_hold_cnt > 0) begin
      out_ready <= 1'b0;
      rx_hold_cnt--;
    end else if (rx_hold_req > 0) begin
      out_ready <= 1'b0;
      rx_hold_cnt = rx_hold_req - 1;
      rx_hold_req = 0;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= ($urandom_range(0, 9) < 7);
        RX_PATTERN: out_ready <= ((rx_tick % 7) < 4);
        default:    out_ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < 50)
      $display("[%0t] header %0d: %s got 0x%0h, want 0x%0h",
               $time, hdrs_checked, what, got, want);
    mismatch_cnt++;
  endtask

  // Result checker: every accepted header word against the oldest prediction
  always @(posedge clk) begin
    rtwhe_out_t want;
    rtwhe_out_t got;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_hdrs.size() == 0) begin
        report_mismatch("unexpected header word", 64'(got.frame_length), 64'd0);
      end else begin
        want = expected_hdrs.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.frame_type !== want.frame_type)
          report_mismatch("frame_type", 64'(got.frame_type), 64'(want.frame_type));
        if (got.frame_subtype !== want.frame_subtype)
          report_mismatch("frame_subtype", 64'(got.frame_subtype), 64'(want.frame_subtype));
        if (got.known_kind !== want.known_kind)
          report_mismatch("known_kind", 64'(got.known_kind), 64'(want.known_kind));
        if (got.dest_address !== want.dest_address)
          report_mismatch("dest_address", 64'(got.dest_address), 64'(want.dest_address));
        if (got.source_address !== want.source_address)
          report_mismatch("source_address", 64'(got.source_address),
                          64'(want.source_address));
        if (got.bss_address !== want.bss_address)
          report_mismatch("bss_address", 64'(got.bss_address), 64'(want.bss_address));
        if (got.frame_length !== want.frame_length)
          report_mismatch("frame_length", 64'(got.frame_length), 64'(want.frame_length));
        if (got.channel_number !== want.channel_number)
          report_mismatch("channel_number", 64'(got.channel_number),
                          64'(want.channel_number));
        if (want.status == STATUS_SHORT) short_checked++;
        if (want.known_kind) known_checked++;
      end
      hdrs_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Too-short captures, channel still at its reset value: single-byte frame,
  // one below the minimum, one short of rt+24, and a huge radiotap length.
  task automatic test_too_short();
    send_frame(8, 1, 16'h0000, FILL_ONE);
    send_frame(8, MIN_CAPTURE_HEADER - 1, 16'h0000, FILL_RAND);
    send_frame(8, 8 + HDR_LEN - 1, 16'h0088, FILL_RAND);
    send_frame(16'hFFFF, 40, 16'h0000, FILL_ONE);
    drain_results();
  endtask

  // Exact-length and padded frames: all four types, subtype extremes,
  // a reserved pair, all-zero and all-one addresses.
  task automatic test_header_kinds();
    send_frame(8, 8 + HDR_LEN, 16'h0000, FILL_ZERO);
    send_frame(8, 8 + HDR_LEN + 6, 16'hFFFF, FILL_ONE);
    for (int ty = 0; ty < 4; ty++)
      send_frame(12, 12 + HDR_LEN + ty, {8'h41, 4'(ty * 5 + 1), 2'(ty), 2'b00}, FILL_RAND);
    send_frame(4, 4 + HDR_LEN, {8'h00, 4'd2, 2'd3, 2'b00}, FILL_RAND);   // reserved ext
    send_frame(20, 20 + HDR_LEN + 3, {8'h00, 4'd15, 2'd1, 2'b00}, FILL_RAND);
    drain_results();
  endtask

  // Radiotap length 0..3: frame control comes from the stored prefix bytes
  task automatic test_short_radiotap();
    for (int rt = 0; rt < 4; rt++)
      send_frame(rt, rt + HDR_LEN + rt, 16'h0000, FILL_RAND);
    drain_results();
  endtask

  // Channel register extremes and a few random settings
  task automatic test_channel_setting();
    set_channel(8'hFF);
    send_frame(8, 8 + HDR_LEN, 16'h0080, FILL_RAND);
    set_channel(8'h00);
    send_frame(10, 10 + HDR_LEN + 1, 16'h0008, FILL_RAND);
    repeat (3) begin
      set_channel(8'($urandom_range(1, 254)));
      send_frame($urandom_range(4, 16), 45, 16'($urandom_range(0, 65535)), FILL_RAND);
    end
    drain_results();
  endtask

  // Captures past 65535 bytes: count saturates, tail is not captured.
  // Exact fit at the saturation point, a fit with extra tail, and a header
  // that only fits if the count did not saturate.
  task automatic test_length_saturation();
    tx_gap_on = 1'b0;
    rx_mode   = RX_OPEN;
    send_frame(65535 - HDR_LEN, 65535, 16'h00D4, FILL_RAND);
    send_frame(65500, 65540, 16'h0088, FILL_RAND);
    send_frame(65520, 65600, 16'h0000, FILL_RAND);
    drain_results();
    tx_gap_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // tiny frames; the result register fills and the input stalls.
  task automatic test_backpressure();
    tx_gap_on   = 1'b0;
    rx_hold_req = 400;
    repeat (30) send_frame(8, $urandom_range(1, 3), 16'h0000, FILL_RAND);
    rx_mode = RX_SPARSE;
    repeat (10) send_frame(8, $urandom_range(1, 2), 16'h0000, FILL_RAND);
    drain_results();
    rx_mode   = RX_RANDOM;
    tx_gap_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, the rest truncated or noise
  task automatic test_random_traffic();
    int frames;
    int nbytes;
    int pick;
    int rt;
    int len;
    frames = 0;
    nbytes = 0;
    while (nbytes < 750 || frames < 36) begin
      if (frames % 12 == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        tx_gap_on = ($urandom_range(0, 3) != 0);
      end
      if (frames % 20 == 19) set_channel(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        rt  = $urandom_range(4, 24);
        len = rt + HDR_LEN + $urandom_range(0, 8);
      end else if (pick < 78) begin
        rt  = $urandom_range(0, 3);
        len = rt + HDR_LEN + $urandom_range(0, 6);
      end else if (pick < 90) begin
        rt  = $urandom_range(0, 24);
        len = $urandom_range(1, rt + HDR_LEN - 1);
      end else begin
        rt  = $urandom_range(0, 65535);
        len = $urandom_range(1, 60);
      end
      send_frame(rt, len, 16'($urandom_range(0, 65535)), FILL_RAND);
      frames++;
      nbytes += len;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    chan        = '0;
    tx_gap_on   = 1'b1;
    burst_left  = 0;
    rx_mode     = RX_RANDOM;
    rx_hold_req = 0;
    rx_hold_cnt = 0;
    rx_tick     = 0;
    clear_frame_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_too_short();
    test_header_kinds();
    test_short_radiotap();
    test_channel_setting();
    test_length_saturation();
    test_backpressure();
    test_random_traffic();

    // Give the last results time to land
    repeat (10) @(posedge clk);
    while (expected_hdrs.size() != 0) begin
      report_mismatch("header word never arrived", 64'd0,
                      64'(expected_hdrs[0].frame_length));
      void'(expected_hdrs.pop_front());
    end

    $display("Checked %0d headers (%0d too short, %0d known kinds) from %0d byte words",
             hdrs_checked, short_checked, known_checked, bytes_sent);
    $display("Channel written %0d times; saturated lengths, rt<4 and long stalls included",
             chan_writes);
    if (mismatch_cnt == 0) begin
      $display("PASS radiotap_wifi_header_extractor");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAIL radiotap_wifi_header_extractor");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d headers outstanding", expected_hdrs.size());
    $display("FAIL radiotap_wifi_header_extractor");
    $finish;
  end

endmodule
